@@ hw/rtl/sckm_pkg.sv @@
// Shared types, widths and codes for the scancode keymap translator.
package sckm_pkg;

   localparam int KEY_W      = 16;
   localparam int CHAR_W     = 8;
   localparam int CODE_W     = 8;
   localparam int OP_W       = 3;
   localparam int CFG_W      = 16;
   localparam int CFG_IW     = 2;
   localparam int MAP_DEPTH  = 256;
   localparam int HALF_DEPTH = MAP_DEPTH / 2;
   localparam int HALF_AW    = $clog2(HALF_DEPTH);
   localparam int CMDQ_DEPTH = 4;
   localparam int RSPQ_DEPTH = 4;

   localparam logic [OP_W-1:0] OP_SCAN       = 3'd0;
   localparam logic [OP_W-1:0] OP_LOAD_BASE  = 3'd1;
   localparam logic [OP_W-1:0] OP_LOAD_ALT   = 3'd2;
   localparam logic [OP_W-1:0] OP_LOAD_SHIFT = 3'd3;
   localparam logic [OP_W-1:0] OP_LOAD_EXT   = 3'd4;

   localparam logic [CFG_IW-1:0] CFG_EXT_PREFIX = 2'd0;
   localparam logic [CFG_IW-1:0] CFG_SHIFT_MASK = 2'd1;
   localparam logic [CFG_IW-1:0] CFG_ALT_MASK   = 2'd2;
   localparam logic [CFG_IW-1:0] CFG_CTRL_MASK  = 2'd3;

   localparam logic [KEY_W-1:0] EXT_PREFIX_RST = 16'hFFFF;
   localparam logic [KEY_W-1:0] SHIFT_MASK_RST = 16'h0100;
   localparam logic [KEY_W-1:0] ALT_MASK_RST   = 16'h0200;
   localparam logic [KEY_W-1:0] CTRL_MASK_RST  = 16'h0400;

   typedef enum logic [2:0] {
      KIND_NOP,
      KIND_SCAN,
      KIND_LOAD_BASE,
      KIND_LOAD_ALT,
      KIND_LOAD_SHIFT,
      KIND_LOAD_EXT,
      KIND_BAD_POS
   } kind_type;

   typedef struct packed {
      logic [OP_W-1:0]   op;
      logic [CODE_W-1:0] code;
      logic [CHAR_W-1:0] char_in;
      logic [KEY_W-1:0]  key_in;
   } req_type;

   typedef struct packed {
      logic              status;
      logic              event_valid;
      logic [KEY_W-1:0]  key_out;
      logic [CHAR_W-1:0] char_out;
      logic              shift_on;
      logic              alt_on;
      logic              ctrl_on;
      logic              ext_on;
      logic              pressed;
   } rsp_type;

   typedef struct packed {
      kind_type          kind;
      logic [CODE_W-1:0] code;
      logic [CHAR_W-1:0] char_in;
      logic [KEY_W-1:0]  key_in;
   } cmd_type;

   typedef struct packed {
      logic [KEY_W-1:0] ext_prefix_key;
      logic [KEY_W-1:0] shift_key_mask;
      logic [KEY_W-1:0] alt_key_mask;
      logic [KEY_W-1:0] ctrl_key_mask;
   } cfg_type;

   typedef struct packed {
      logic [KEY_W-1:0]  key;
      logic [CHAR_W-1:0] ascii;
   } var_entry_type;

   typedef struct packed {
      logic [CODE_W-1:0] pos;
      logic              pressed;
   } pos_entry_type;

   typedef struct packed {
      logic has_one;
      logic has_two;
   } rspq_status_type;

   localparam int VAR_W = $bits(var_entry_type);
   localparam int POS_W = $bits(pos_entry_type);

endpackage

@@ hw/rtl/sckm_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module sckm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hw/rtl/sckm_csr.sv @@
// Configuration registers: extended-prefix key and modifier key masks.
module sckm_csr (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        wr_en,
   input  logic [sckm_pkg::CFG_IW-1:0] index,
   input  logic [sckm_pkg::CFG_W-1:0]  wdata,
   output sckm_pkg::cfg_type           cfg
);
   import sckm_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (index)
            CFG_EXT_PREFIX: cfg_in.ext_prefix_key = KEY_W'(wdata);
            CFG_SHIFT_MASK: cfg_in.shift_key_mask = KEY_W'(wdata);
            CFG_ALT_MASK:   cfg_in.alt_key_mask   = KEY_W'(wdata);
            CFG_CTRL_MASK:  cfg_in.ctrl_key_mask  = KEY_W'(wdata);
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.ext_prefix_key <= EXT_PREFIX_RST;
         cfg_ff.shift_key_mask <= SHIFT_MASK_RST;
         cfg_ff.alt_key_mask   <= ALT_MASK_RST;
         cfg_ff.ctrl_key_mask  <= CTRL_MASK_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

@@ hw/rtl/sckm_front.sv @@
// Front end: accepts requests, decodes them into commands and queues them.
module sckm_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   output logic              full,
   input  sckm_pkg::req_type req,
   input  logic              init_busy,
   output logic              cmd_valid,
   output sckm_pkg::cmd_type cmd,
   input  logic              cmd_pop
);
   import sckm_pkg::*;

   localparam int QAW = $clog2(CMDQ_DEPTH);
   localparam int QCW = $clog2(CMDQ_DEPTH + 1);

   cmd_type          q_ff [CMDQ_DEPTH];
   logic [QAW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QAW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCW-1:0]   count_ff, count_in;
   cmd_type          dec;
   logic             do_push;
   logic             do_pop;

   always_comb begin
      dec.code    = req.code;
      dec.char_in = req.char_in;
      dec.key_in  = req.key_in;
      unique case (req.op)
         OP_SCAN:       dec.kind = KIND_SCAN;
         OP_LOAD_BASE:  dec.kind = KIND_LOAD_BASE;
         OP_LOAD_ALT:   dec.kind = req.code[CODE_W-1] ? KIND_BAD_POS : KIND_LOAD_ALT;
         OP_LOAD_SHIFT: dec.kind = req.code[CODE_W-1] ? KIND_BAD_POS : KIND_LOAD_SHIFT;
         OP_LOAD_EXT:   dec.kind = req.code[CODE_W-1] ? KIND_BAD_POS : KIND_LOAD_EXT;
         default:       dec.kind = KIND_NOP;
      endcase
   end

   // hold off requests while the keymap is being cleared
   assign full    = (count_ff == QCW'(CMDQ_DEPTH)) || init_busy;
   assign do_push = push && !full;
   assign do_pop  = cmd_pop && cmd_valid;

   assign cmd_valid = (count_ff != '0);
   assign cmd       = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         q_ff[wr_ptr_ff] <= dec;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

@@ hw/rtl/sckm_back.sv @@
// Back end: keymap memories, clearing sweep, scancode evaluation and key state.
module sckm_back (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      cmd_valid,
   input  sckm_pkg::cmd_type         cmd,
   output logic                      cmd_pop,
   input  sckm_pkg::cfg_type         cfg,
   input  sckm_pkg::rspq_status_type rspq,
   output logic                      rsp_push,
   output sckm_pkg::rsp_type         rsp,
   output logic                      init_busy
);
   import sckm_pkg::*;

   // clearing sweep
   logic               clr_busy_ff, clr_busy_in;
   logic [HALF_AW-1:0] clr_idx_ff, clr_idx_in;

   // evaluation stage
   logic               s2_valid_ff;
   kind_type           s2_kind_ff;
   logic [CODE_W-1:0]  s2_code_ff;

   // key state
   logic               held_valid_ff, held_valid_in;
   logic [CODE_W-1:0]  held_pos_ff, held_pos_in;
   logic [CODE_W-1:0]  held_shadow_ff, held_shadow_in;
   logic [KEY_W-1:0]   held_key_ff, held_key_in;
   logic [CHAR_W-1:0]  held_char_ff, held_char_in;
   logic               shift_ff, shift_in;
   logic               alt_ff, alt_in;
   logic               ctrl_ff, ctrl_in;
   logic               ext_ff, ext_in;

   logic               issue;
   logic               load_wr;
   logic [HALF_AW-1:0] wr_addr;
   logic [HALF_AW-1:0] rd_addr;
   var_entry_type      var_wdata;

   logic [VAR_W-1:0]   kc_rd [2];
   logic [POS_W-1:0]   pos_rd [2];
   logic [VAR_W-1:0]   sh_rd [2];
   logic [VAR_W-1:0]   al_rd [2];
   logic [VAR_W-1:0]   ex_rd [2];

   var_entry_type      e_kc;
   pos_entry_type      e_pos;
   var_entry_type      e_sh;
   var_entry_type      e_al;
   var_entry_type      e_ex;
   logic               found;
   logic               keep_ext;
   logic               shadow_hit;

   assign init_busy = clr_busy_ff;

   // keep room in the result queue for the command in flight
   assign issue   = cmd_valid && !clr_busy_ff && (s2_valid_ff ? rspq.has_two : rspq.has_one);
   assign cmd_pop = issue;
   assign load_wr = issue && (cmd.kind == KIND_LOAD_BASE || cmd.kind == KIND_LOAD_ALT ||
                              cmd.kind == KIND_LOAD_SHIFT || cmd.kind == KIND_LOAD_EXT);

   assign wr_addr = clr_busy_ff ? clr_idx_ff : cmd.code[HALF_AW-1:0];
   assign rd_addr = cmd.code[HALF_AW-1:0];

   always_comb begin
      var_wdata = '0;
      if (!clr_busy_ff) begin
         var_wdata.key   = cmd.key_in;
         var_wdata.ascii = cmd.char_in;
      end
   end

   // low half holds codes 0..127, high half the release twins 128..255
   for (genvar h = 0; h < 2; h++) begin : g_half
      logic          half_en;
      logic          kc_we;
      logic          pos_we;
      logic          sh_we;
      logic          al_we;
      logic          ex_we;
      pos_entry_type pos_wdata;

      assign half_en = (h == 1) || !cmd.code[CODE_W-1];
      assign kc_we   = clr_busy_ff || (issue && cmd.kind == KIND_LOAD_BASE && half_en);
      assign pos_we  = clr_busy_ff || (load_wr && half_en);
      assign sh_we   = clr_busy_ff || (issue && cmd.kind == KIND_LOAD_SHIFT);
      assign al_we   = clr_busy_ff || (issue && cmd.kind == KIND_LOAD_ALT);
      assign ex_we   = clr_busy_ff || (issue && cmd.kind == KIND_LOAD_EXT);

      always_comb begin
         pos_wdata = '0;
         if (!clr_busy_ff) begin
            pos_wdata.pos     = cmd.code;
            pos_wdata.pressed = (h == 0) || cmd.code[CODE_W-1];
         end
      end

      sckm_ram #(.WIDTH(VAR_W), .DEPTH(HALF_DEPTH)) u_base_kc (
         .clock   (clock),
         .wr_en   (kc_we),
         .wr_addr (wr_addr),
         .wr_data (var_wdata),
         .rd_addr (rd_addr),
         .rd_data (kc_rd[h])
      );

      sckm_ram #(.WIDTH(POS_W), .DEPTH(HALF_DEPTH)) u_base_pos (
         .clock   (clock),
         .wr_en   (pos_we),
         .wr_addr (wr_addr),
         .wr_data (pos_wdata),
         .rd_addr (rd_addr),
         .rd_data (pos_rd[h])
      );

      sckm_ram #(.WIDTH(VAR_W), .DEPTH(HALF_DEPTH)) u_shift_map (
         .clock   (clock),
         .wr_en   (sh_we),
         .wr_addr (wr_addr),
         .wr_data (var_wdata),
         .rd_addr (rd_addr),
         .rd_data (sh_rd[h])
      );

      sckm_ram #(.WIDTH(VAR_W), .DEPTH(HALF_DEPTH)) u_alt_map (
         .clock   (clock),
         .wr_en   (al_we),
         .wr_addr (wr_addr),
         .wr_data (var_wdata),
         .rd_addr (rd_addr),
         .rd_data (al_rd[h])
      );

      sckm_ram #(.WIDTH(VAR_W), .DEPTH(HALF_DEPTH)) u_ext_map (
         .clock   (clock),
         .wr_en   (ex_we),
         .wr_addr (wr_addr),
         .wr_data (var_wdata),
         .rd_addr (rd_addr),
         .rd_data (ex_rd[h])
      );
   end

   assign e_kc  = var_entry_type'(kc_rd[s2_code_ff[CODE_W-1]]);
   assign e_pos = pos_entry_type'(pos_rd[s2_code_ff[CODE_W-1]]);
   assign e_sh  = var_entry_type'(sh_rd[s2_code_ff[CODE_W-1]]);
   assign e_al  = var_entry_type'(al_rd[s2_code_ff[CODE_W-1]]);
   assign e_ex  = var_entry_type'(ex_rd[s2_code_ff[CODE_W-1]]);

   always_comb begin
      clr_busy_in = clr_busy_ff;
      clr_idx_in  = clr_idx_ff;
      if (clr_busy_ff) begin
         clr_idx_in = clr_idx_ff + 1'b1;
         if (clr_idx_ff == HALF_AW'(HALF_DEPTH - 1)) begin
            clr_busy_in = 1'b0;
         end
      end
   end

   always_comb begin
      held_valid_in  = held_valid_ff;
      held_pos_in    = held_pos_ff;
      held_shadow_in = held_shadow_ff;
      held_key_in    = held_key_ff;
      held_char_in   = held_char_ff;
      shift_in       = shift_ff;
      alt_in         = alt_ff;
      ctrl_in        = ctrl_ff;
      ext_in         = ext_ff;
      found          = 1'b0;
      keep_ext       = 1'b0;
      rsp            = '0;

      if (s2_valid_ff && s2_kind_ff == KIND_SCAN) begin
         if (e_kc.key == cfg.ext_prefix_key) begin
            ext_in   = 1'b1;
            keep_ext = 1'b1;
            found    = 1'b1;
         end else if ((e_kc.key & cfg.shift_key_mask) != '0) begin
            shift_in = e_pos.pressed;
            found    = 1'b1;
         end else if ((e_kc.key & cfg.alt_key_mask) != '0) begin
            alt_in = e_pos.pressed;
            found  = 1'b1;
         end else if ((e_kc.key & cfg.ctrl_key_mask) != '0) begin
            ctrl_in = e_pos.pressed;
            found   = 1'b1;
         end else if (e_pos.pressed) begin
            // variant priority: shift, alt, extended, then base
            if (shift_ff && e_sh.key != '0) begin
               held_key_in  = e_sh.key;
               held_char_in = e_sh.ascii;
               found        = 1'b1;
            end else if (alt_ff && e_al.key != '0) begin
               held_key_in  = e_al.key;
               held_char_in = e_al.ascii;
               found        = 1'b1;
            end else if (ext_ff && e_ex.key != '0) begin
               held_key_in  = e_ex.key;
               held_char_in = e_ex.ascii;
               found        = 1'b1;
            end else if (e_kc.key != '0) begin
               held_key_in  = e_kc.key;
               held_char_in = e_kc.ascii;
               found        = 1'b1;
            end
            if (found) begin
               held_valid_in  = 1'b1;
               held_pos_in    = s2_code_ff;
               held_shadow_in = e_pos.pos;
            end
         end else if (held_valid_ff && held_shadow_ff == e_pos.pos) begin
            found         = 1'b1;
            held_valid_in = 1'b0;
            held_pos_in   = '0;
            held_key_in   = '0;
            held_char_in  = '0;
         end

         rsp.event_valid = found;
         rsp.key_out     = held_key_in;
         rsp.char_out    = held_char_in;
         rsp.shift_on    = shift_in;
         rsp.alt_on      = alt_in;
         rsp.ctrl_on     = ctrl_in;
         rsp.ext_on      = ext_in;
         rsp.pressed     = e_pos.pressed;
         if (!keep_ext) begin
            ext_in = 1'b0;
         end
      end else if (s2_valid_ff) begin
         rsp.status = (s2_kind_ff == KIND_BAD_POS);
      end

      // track the stored position of the held entry when a younger load rewrites it
      shadow_hit = load_wr && held_valid_in &&
                   (held_pos_in[HALF_AW-1:0] == cmd.code[HALF_AW-1:0]) &&
                   (held_pos_in[CODE_W-1] || !cmd.code[CODE_W-1]);
      if (shadow_hit) begin
         held_shadow_in = cmd.code;
      end
   end

   assign rsp_push = s2_valid_ff;

   always_ff @(posedge clock) begin
      s2_kind_ff <= cmd.kind;
      s2_code_ff <= cmd.code;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff    <= 1'b1;
         clr_idx_ff     <= '0;
         s2_valid_ff    <= 1'b0;
         held_valid_ff  <= 1'b0;
         held_pos_ff    <= '0;
         held_shadow_ff <= '0;
         held_key_ff    <= '0;
         held_char_ff   <= '0;
         shift_ff       <= 1'b0;
         alt_ff         <= 1'b0;
         ctrl_ff        <= 1'b0;
         ext_ff         <= 1'b0;
      end else begin
         clr_busy_ff    <= clr_busy_in;
         clr_idx_ff     <= clr_idx_in;
         s2_valid_ff    <= issue;
         held_valid_ff  <= held_valid_in;
         held_pos_ff    <= held_pos_in;
         held_shadow_ff <= held_shadow_in;
         held_key_ff    <= held_key_in;
         held_char_ff   <= held_char_in;
         shift_ff       <= shift_in;
         alt_ff         <= alt_in;
         ctrl_ff        <= ctrl_in;
         ext_ff         <= ext_in;
      end
   end

endmodule

@@ hw/rtl/sckm_rspq.sv @@
// Result queue between the back end and the consumer.
module sckm_rspq (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  sckm_pkg::rsp_type         wdata,
   output sckm_pkg::rspq_status_type status,
   output logic                      empty,
   input  logic                      pop,
   output sckm_pkg::rsp_type         rdata
);
   import sckm_pkg::*;

   localparam int QAW = $clog2(RSPQ_DEPTH);
   localparam int QCW = $clog2(RSPQ_DEPTH + 1);

   rsp_type        q_ff [RSPQ_DEPTH];
   logic [QAW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QAW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCW-1:0] count_ff, count_in;
   logic           do_pop;

   assign empty          = (count_ff == '0);
   assign rdata          = q_ff[rd_ptr_ff];
   assign do_pop         = pop && !empty;
   assign status.has_one = (count_ff < QCW'(RSPQ_DEPTH));
   assign status.has_two = (count_ff < QCW'(RSPQ_DEPTH - 1));

   always_comb begin
      wr_ptr_in = push   ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

@@ hw/rtl/scancode_keymap_translator_core.sv @@
// Path: an accepted request waits in the command queue, is issued to the evaluation
// register and its result is written to the result queue, where rsp_data shows it.
// Throughput: one request per cycle while no clearing pass runs and the result queue
// has room; each keymap half has one write port, so a load and its release twin
// are written together. Reset: synchronous; then a clearing pass zeroes the keymap
// while req_full stays high. Configuration writes are taken throughout.
module scancode_keymap_translator_core (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_push,
   output logic                        req_full,
   input  sckm_pkg::req_type           req_data,
   output logic                        rsp_empty,
   input  logic                        rsp_pop,
   output sckm_pkg::rsp_type           rsp_data,
   input  logic                        csr_wr_en,
   input  logic [sckm_pkg::CFG_IW-1:0] csr_index,
   input  logic [sckm_pkg::CFG_W-1:0]  csr_wdata
);
   import sckm_pkg::*;

   cfg_type         cfg;
   cmd_type         cmd;
   logic            cmd_valid;
   logic            cmd_pop;
   logic            init_busy;
   logic            rsp_push;
   rsp_type         rsp_wdata;
   rspq_status_type rspq_status;

   sckm_csr u_csr (
      .clock (clock),
      .reset (reset),
      .wr_en (csr_wr_en),
      .index (csr_index),
      .wdata (csr_wdata),
      .cfg   (cfg)
   );

   sckm_front u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (req_push),
      .full      (req_full),
      .req       (req_data),
      .init_busy (init_busy),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop)
   );

   sckm_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop),
      .cfg       (cfg),
      .rspq      (rspq_status),
      .rsp_push  (rsp_push),
      .rsp       (rsp_wdata),
      .init_busy (init_busy)
   );

   sckm_rspq u_rspq (
      .clock  (clock),
      .reset  (reset),
      .push   (rsp_push),
      .wdata  (rsp_wdata),
      .status (rspq_status),
      .empty  (rsp_empty),
      .pop    (rsp_pop),
      .rdata  (rsp_data)
   );

endmodule
